// ===== hdl/per_agent_curvature_hysteresis_alert_core_assert.svh =====
// assertion macros for the curvature hysteresis alert checker
// expects aclk and aresetn to be visible where a macro is used
`ifndef PER_AGENT_CURVATURE_HYSTERESIS_ALERT_CORE_ASSERT_SVH
`define PER_AGENT_CURVATURE_HYSTERESIS_ALERT_CORE_ASSERT_SVH

// antecedent this cycle, consequent on the next cycle, masked during reset
`define PCHA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pcha check failed");

// checks that hold across reset itself
`define PCHA_ASSERT_RESET(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("pcha reset check failed");

`endif

// ===== hdl/pcha_pkg.sv =====
// shared types and constants for the curvature hysteresis alert core
// no dependencies
`default_nettype none

package pcha_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ID_W = 32;
    localparam int ENTRY_W = ID_W + 1;
    localparam logic [15:0] MIN_TRAIL = 16'd4;

    localparam logic [1:0] REG_WATCHED_ROLE = 2'd0;
    localparam logic [1:0] REG_CURVATURE_LIMIT = 2'd1;
    localparam logic [1:0] REG_HYSTERESIS_BAND = 2'd2;

    typedef struct packed {
        logic [7:0]         agent_role;
        logic [31:0]        agent_id;
        logic [15:0]        trail_length;
        logic signed [31:0] curvature;
        logic [31:0]        frame_time;
        logic [31:0]        frame_tick;
        logic               frame_last;
    } in_word_t;

    typedef struct packed {
        logic [31:0]        event_agent;
        logic signed [31:0] event_curvature;
        logic signed [31:0] event_limit;
        logic               stealth_lost;
        logic [31:0]        event_time;
        logic [31:0]        event_tick;
    } out_word_t;

endpackage

`default_nettype wire

// ===== hdl/pcha_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module pcha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                     aclk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/per_agent_curvature_hysteresis_alert_core.sv =====
// Curvature hysteresis alert with a per-agent stealth flag table. Each input word is taken
// only while s_ready is high; the core then holds s_ready low while it works on that word.
// A word whose role or trail length rules it out is dropped after the prep step. Otherwise
// the id search reads one table entry per cycle through the single read port of the table
// ram and compares it; an unknown id is dropped when the table of 64 agents is full, and
// else one evaluate step checks the thresholds and writes the entry back when it is new or
// its flag changes. A word that raises an event stays in the evaluate state until the
// output register is free. The table needs no clearing pass after reset. A result word
// waits in the output register while the next input word is being taken and searched.
// depends on pcha_pkg and pcha_ram
`default_nettype none

module per_agent_curvature_hysteresis_alert_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire pcha_pkg::in_word_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output pcha_pkg::out_word_t       m_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EVAL = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]         role_reg;
    logic signed [31:0] limit_reg;
    logic [30:0]        band_reg;

    pcha_pkg::in_word_t  item_reg, item_next;
    pcha_pkg::out_word_t out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    logic [pcha_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [pcha_pkg::CNT_W-1:0] used_reg, used_next;
    logic                       pend_reg, pend_next;
    logic [pcha_pkg::IDX_W-1:0] pidx_reg, pidx_next;
    logic [pcha_pkg::IDX_W-1:0] slot_reg, slot_next;
    logic                       flag_reg, flag_next;
    logic                       new_reg, new_next;

    logic                         ram_we;
    logic [pcha_pkg::ENTRY_W-1:0] ram_wdata;
    logic [pcha_pkg::ENTRY_W-1:0] ram_rdata;

    logic               over;
    logic               settled;
    logic               lost_ev;
    logic               regain_ev;
    logic               out_free;
    logic signed [33:0] thresh;
    logic signed [33:0] curv_ext;

    pcha_ram #(
        .WIDTH(pcha_pkg::ENTRY_W),
        .DEPTH(pcha_pkg::TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg[pcha_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            role_reg  <= '0;
            limit_reg <= '0;
            band_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pcha_pkg::REG_WATCHED_ROLE:    role_reg  <= cfg_wdata[7:0];
                pcha_pkg::REG_CURVATURE_LIMIT: limit_reg <= cfg_wdata;
                pcha_pkg::REG_HYSTERESIS_BAND: band_reg  <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // threshold compare, limit minus band kept exact at 34 bits
    assign thresh    = $signed({{2{limit_reg[31]}}, limit_reg}) - $signed({3'b000, band_reg});
    assign curv_ext  = $signed({{2{item_reg.curvature[31]}}, item_reg.curvature});
    assign over      = item_reg.curvature > limit_reg;
    assign settled   = !over && (curv_ext < thresh);
    assign lost_ev   = over && flag_reg;
    assign regain_ev = settled && !flag_reg;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        idx_next     = idx_reg;
        used_next    = used_reg;
        pend_next    = pend_reg;
        pidx_next    = pidx_reg;
        slot_next    = slot_reg;
        flag_next    = flag_reg;
        new_next     = new_reg;
        ram_we       = 1'b0;
        ram_wdata    = {item_reg.agent_id, flag_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                idx_next  = '0;
                pend_next = 1'b0;
                if (item_reg.agent_role != role_reg
                        || item_reg.trail_length < pcha_pkg::MIN_TRAIL) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                pend_next = 1'b0;
                if (pend_reg && ram_rdata[pcha_pkg::ENTRY_W-1:1] == item_reg.agent_id) begin
                    slot_next  = pidx_reg;
                    flag_next  = ram_rdata[0];
                    new_next   = 1'b0;
                    state_next = ST_EVAL;
                end else if (idx_reg == used_reg) begin
                    if (used_reg == pcha_pkg::CNT_W'(pcha_pkg::TABLE_ENTRIES)) begin
                        state_next = ST_IDLE;
                    end else begin
                        slot_next  = used_reg[pcha_pkg::IDX_W-1:0];
                        flag_next  = 1'b1;
                        new_next   = 1'b1;
                        state_next = ST_EVAL;
                    end
                end else begin
                    pend_next = 1'b1;
                    pidx_next = idx_reg[pcha_pkg::IDX_W-1:0];
                    idx_next  = idx_reg + pcha_pkg::CNT_W'(1);
                end
            end
            ST_EVAL: begin
                if (!(lost_ev || regain_ev) || out_free) begin
                    ram_we    = new_reg || lost_ev || regain_ev;
                    ram_wdata = {item_reg.agent_id, flag_reg ^ (lost_ev || regain_ev)};
                    used_next = used_reg + pcha_pkg::CNT_W'(new_reg);
                    if (lost_ev || regain_ev) begin
                        out_next.event_agent     = item_reg.agent_id;
                        out_next.event_curvature = item_reg.curvature;
                        out_next.event_limit     = limit_reg;
                        out_next.stealth_lost    = lost_ev;
                        out_next.event_time      = item_reg.frame_time;
                        out_next.event_tick      = item_reg.frame_tick;
                        m_valid_next             = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            used_reg    <= '0;
            pend_reg    <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            used_reg    <= used_next;
            pend_reg    <= pend_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        out_reg  <= out_next;
        pidx_reg <= pidx_next;
        slot_reg <= slot_next;
        flag_reg <= flag_next;
        new_reg  <= new_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== hdl/pcha_checker.sv =====
// port level checks for the curvature hysteresis alert core, bound to the top level
// depends on pcha_pkg and the assertion macro header
`default_nettype none

`include "per_agent_curvature_hysteresis_alert_core_assert.svh"

module pcha_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire pcha_pkg::out_word_t m_data
);

    // held result word stays put
    `PCHA_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    // one word at a time: busy right after taking a word
    `PCHA_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    // no result can appear in the cycle right after a word is taken
    `PCHA_ASSERT_NEXT(a_no_instant_result, s_valid && s_ready && !m_valid, !m_valid)
    // reset leaves the core empty and ready
    `PCHA_ASSERT_RESET(a_reset_state, !aresetn, !m_valid && s_ready)

endmodule

bind per_agent_curvature_hysteresis_alert_core pcha_checker u_pcha_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ===== bench/per_agent_curvature_hysteresis_alert_core_test.sv =====
// self-checking bench for per_agent_curvature_hysteresis_alert_core: random agent samples
// against a per-agent stealth flag predictor, with idle and stall bursts on both channels
// depends on pcha_pkg and the core rtl
`timescale 1ns / 1ps

module per_agent_curvature_hysteresis_alert_core_test;
    import pcha_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 80;
    localparam int STUCK_LIMIT = 2000;
    localparam int PRINT_LIMIT = 100;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_word_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_word_t   m_data;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    per_agent_curvature_hysteresis_alert_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [7:0]         watch_role;
    logic signed [31:0] stealth_limit;
    logic [30:0]        regain_band;
    logic [31:0]        agent_ids [TABLE_ENTRIES];
    bit                 agent_unseen [TABLE_ENTRIES];
    int                 agents_known;

    in_word_t  pending_words [$];
    out_word_t alerts_due [$];
    logic [31:0] agent_pool [$];
    bit          pool_has [bit [31:0]];

    int words_sent = 0;
    int words_taken = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    bit s_took = 1'b0;

    task automatic report_mismatch(string what);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    function automatic void predict_alert(in_word_t w);
        int        slot;
        int        i;
        longint    curv;
        longint    lim;
        longint    regain_below;
        bit        over;
        bit        settled;
        out_word_t alert;
        if (w.agent_role != watch_role || w.trail_length < MIN_TRAIL)
            return;
        slot = -1;
        for (i = 0; i < agents_known; i++) begin
            if (agent_ids[i] == w.agent_id) begin
                slot = i;
                break;
            end
        end
        if (slot < 0) begin
            if (agents_known >= TABLE_ENTRIES)
                return;
            slot = agents_known;
            agent_ids[slot] = w.agent_id;
            agent_unseen[slot] = 1'b1;
            agents_known++;
        end
        curv = longint'(w.curvature);
        lim = longint'(stealth_limit);
        regain_below = lim - longint'({1'b0, regain_band});
        over = curv > lim;
        settled = !over && curv < regain_below;
        if (over && agent_unseen[slot]) begin
            agent_unseen[slot] = 1'b0;
            alert.stealth_lost = 1'b1;
        end else if (settled && !agent_unseen[slot]) begin
            agent_unseen[slot] = 1'b1;
            alert.stealth_lost = 1'b0;
        end else begin
            return;
        end
        alert.event_agent = w.agent_id;
        alert.event_curvature = w.curvature;
        alert.event_limit = stealth_limit;
        alert.event_time = w.frame_time;
        alert.event_tick = w.frame_tick;
        alerts_due.push_back(alert);
    endfunction

    task automatic check_alert(out_word_t got);
        out_word_t want;
        if (alerts_due.size() == 0) begin
            report_mismatch($sformatf("alert for agent %h with none pending", got.event_agent));
            return;
        end
        want = alerts_due.pop_front();
        check_field("event_agent", got.event_agent, want.event_agent);
        check_field("event_curvature", got.event_curvature, want.event_curvature);
        check_field("event_limit", got.event_limit, want.event_limit);
        check_field("stealth_lost", {31'd0, got.stealth_lost}, {31'd0, want.stealth_lost});
        check_field("event_time", got.event_time, want.event_time);
        check_field("event_tick", got.event_tick, want.event_tick);
    endtask

    // monitor: both handshakes sampled at the rising edge
    always @(posedge aclk) begin : watch_ports
        s_took = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                s_took = 1'b1;
                words_taken++;
                predict_alert(s_data);
            end
            if (m_valid && m_ready)
                check_alert(m_data);
            if (s_took || (m_valid && m_ready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // input word driver
    always @(negedge aclk) begin : drive_words
        logic     next_valid;
        in_word_t next_data;
        next_valid = s_valid;
        next_data = s_data;
        if (aresetn && (!s_valid || s_took)) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
                send_gap = $urandom_range(1, 10) - 1;
            end else if (pending_words.size() > 0) begin
                next_valid = 1'b1;
                next_data = pending_words.pop_front();
            end
        end
        s_valid <= next_valid;
        s_data <= next_data;
    end

    // result ready with stall bursts
    always @(negedge aclk) begin : drive_ready
        if (recv_stall > 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else if (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct) begin
            recv_stall = $urandom_range(1, 10) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin : watchdog
        wait (aresetn);
        wait (quiet_cycles >= STUCK_LIMIT);
        $display("per_agent_curvature_hysteresis_alert_core_test NOT OK");
        $finish;
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_WATCHED_ROLE:    watch_role = value[7:0];
            REG_CURVATURE_LIMIT: stealth_limit = value;
            REG_HYSTERESIS_BAND: regain_band = value[30:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain;
        while (words_taken != words_sent || alerts_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_word(in_word_t w);
        pending_words.push_back(w);
        words_sent++;
    endtask

    function automatic in_word_t make_word(logic [7:0] role, logic [31:0] id,
                                           logic [15:0] trail, logic [31:0] curv);
        in_word_t w;
        w.agent_role = role;
        w.agent_id = id;
        w.trail_length = trail;
        w.curvature = curv;
        w.frame_time = $urandom;
        w.frame_tick = $urandom;
        w.frame_last = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // curvature aimed at the limit and the regain threshold, clamped to 32 bits
    function automatic logic [31:0] pick_curvature;
        longint lim;
        longint regain_below;
        longint curv;
        lim = longint'(stealth_limit);
        regain_below = lim - longint'({1'b0, regain_band});
        case ($urandom_range(0, 7))
            0, 1:    curv = lim + $urandom_range(1, 1000);
            2, 3:    curv = regain_below - $urandom_range(1, 1000);
            4:       curv = lim;
            5:       curv = regain_below;
            6:       curv = (lim > regain_below) ?
                            regain_below + longint'($urandom) % (lim - regain_below) : lim;
            default: curv = longint'($signed($urandom));
        endcase
        if (curv > 64'sd2147483647)
            curv = 64'sd2147483647;
        if (curv < -64'sd2147483648)
            curv = -64'sd2147483648;
        return curv[31:0];
    endfunction

    function automatic logic [31:0] fresh_id;
        logic [31:0] id;
        id = $urandom;
        while (pool_has.exists(id))
            id = $urandom;
        return id;
    endfunction

    function automatic in_word_t random_word(int n_active, bit table_full);
        int          pick;
        logic [7:0]  role_flip;
        logic [15:0] trail;
        logic [31:0] id;
        logic [7:0]  role;
        pick = $urandom_range(0, 99);
        role_flip = 8'($urandom_range(1, 255));
        role = watch_role;
        id = agent_pool[$urandom_range(0, n_active - 1)];
        trail = ($urandom_range(0, 3) == 0) ? MIN_TRAIL : 16'($urandom_range(4, 65535));
        if (pick < 8) begin
            role = watch_role ^ role_flip;
        end else if (pick < 15) begin
            trail = 16'($urandom_range(0, MIN_TRAIL - 1));
        end else if (pick < 20) begin
            if (table_full)
                id = fresh_id();
            else
                role = watch_role ^ role_flip;
        end
        return make_word(role, id, trail, pick_curvature());
    endfunction

    task automatic run_phase(logic [7:0] role, logic [31:0] limit, logic [30:0] band,
                             int count, int n_active, bit fill_table, bit table_full,
                             int gap_pct, int stall_pct);
        int i;
        drain();
        write_reg(REG_WATCHED_ROLE, ($urandom & 32'hFFFF_FF00) | {24'd0, role});
        write_reg(REG_CURVATURE_LIMIT, limit);
        write_reg(REG_HYSTERESIS_BAND, {1'($urandom_range(0, 1)), band});
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        if (fill_table) begin
            for (i = 0; i < TABLE_ENTRIES; i++)
                queue_word(make_word(watch_role, agent_pool[i],
                                     16'($urandom_range(4, 65535)), pick_curvature()));
        end
        for (i = 0; i < count; i++)
            queue_word(random_word(n_active, table_full));
    endtask

    initial begin : stimulus
        logic [31:0] cand;
        in_word_t    w;
        agents_known = 0;
        watch_role = '0;
        stealth_limit = '0;
        regain_band = '0;
        agent_pool.push_back(32'h0000_0000);
        agent_pool.push_back(32'hFFFF_FFFF);
        agent_pool.push_back(32'hAAAA_AAAA);
        agent_pool.push_back(32'h5555_5555);
        foreach (agent_pool[i])
            pool_has[agent_pool[i]] = 1'b1;
        while (agent_pool.size() < TABLE_ENTRIES) begin
            cand = $urandom;
            if (!pool_has.exists(cand)) begin
                pool_has[cand] = 1'b1;
                agent_pool.push_back(cand);
            end
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: limit 1.0, band 0.5
        write_reg(REG_UNUSED, $urandom);
        write_reg(REG_WATCHED_ROLE, 32'h0000_005A);
        write_reg(REG_CURVATURE_LIMIT, 32'h0001_0000);
        write_reg(REG_HYSTERESIS_BAND, 32'h8000_8000);
        send_gap_pct = 20;
        recv_stall_pct = 20;
        w = make_word(8'h5A, 32'h0000_0000, 16'd4, 32'h0001_0001);
        w.frame_time = '0;
        w.frame_tick = '0;
        w.frame_last = 1'b0;
        queue_word(w);
        queue_word(make_word(8'h5A, 32'h0000_0000, 16'd4, 32'h0001_0000));
        queue_word(make_word(8'h5A, 32'h0000_0000, 16'd4, 32'h0000_8000));
        w = make_word(8'h5A, 32'h0000_0000, 16'd4, 32'h0000_7FFF);
        w.frame_time = '1;
        w.frame_tick = '1;
        w.frame_last = 1'b1;
        queue_word(w);
        queue_word(make_word(8'h5A, 32'hFFFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF));
        queue_word(make_word(8'h5A, 32'hFFFF_FFFF, 16'hFFFF, 32'h8000_0000));
        queue_word(make_word(8'h5A, 32'h0000_0000, 16'd3, 32'h7FFF_FFFF));
        queue_word(make_word(8'h5A, 32'h0000_0000, 16'd0, 32'h7FFF_FFFF));
        queue_word(make_word(8'h5B, 32'h0000_0000, 16'd100, 32'h7FFF_FFFF));
        queue_word(make_word(8'h00, 32'h0000_0000, 16'd100, 32'h7FFF_FFFF));
        queue_word(make_word(8'hFF, 32'h0000_0000, 16'd100, 32'h7FFF_FFFF));
        queue_word(make_word(8'h5A, 32'h0000_0000, 16'd5, 32'h7FFF_FFFF));
        queue_word(make_word(8'h5A, 32'h0000_0000, 16'd5, 32'h7FFF_FFFF));
        queue_word(make_word(8'h5A, 32'h0000_0000, 16'd5, 32'h8000_0000));
        queue_word(make_word(8'h5A, 32'hFFFF_FFFF, 16'd4, 32'h0001_0001));
        queue_word(make_word(8'h5A, 32'hFFFF_FFFF, 16'd4, 32'h0000_FFFF));
        queue_word(make_word(8'h5A, 32'hFFFF_FFFF, 16'd4, 32'h0000_8000));
        queue_word(make_word(8'h5A, 32'hFFFF_FFFF, 16'd4, 32'h8000_0000));

        run_phase(8'($urandom_range(0, 255)), $urandom_range(0, 32'h8_0000) - 32'h4_0000,
                  31'($urandom_range(0, 32'h2_0000)), 240, 8, 1'b0, 1'b0, 25, 25);
        run_phase(8'h00, 32'h7FFF_FFFF, 31'd0, 200, 16, 1'b0, 1'b0, 0, 0);
        run_phase(8'hFF, 32'h8000_0000, 31'h7FFF_FFFF, 200, 16, 1'b0, 1'b0, 40, 10);
        run_phase(8'($urandom_range(0, 255)), 32'h0000_0000, 31'h7FFF_FFFF,
                  200, 24, 1'b0, 1'b0, 10, 40);
        run_phase(8'($urandom_range(0, 255)), $urandom, 31'($urandom_range(0, 32'hF_FFFF)),
                  250, TABLE_ENTRIES, 1'b1, 1'b0, 25, 25);
        run_phase(8'($urandom_range(0, 255)), $urandom_range(0, 32'h8_0000) - 32'h4_0000,
                  31'($urandom_range(0, 32'h2_0000)), 360, TABLE_ENTRIES, 1'b0, 1'b1, 0, 0);

        drain();
        if (mismatches == 0 && alerts_due.size() == 0)
            $display("per_agent_curvature_hysteresis_alert_core_test OK");
        else
            $display("per_agent_curvature_hysteresis_alert_core_test NOT OK");
        $finish;
    end

endmodule
